>>> hdl/psev_pkg.sv
// shared types and constants for the polynomial surface evaluator
`default_nettype none
package psev_pkg;

  localparam int COORD_W   = 16;
  localparam int COEF_W    = 32;
  localparam int Z_W       = 48;
  localparam int DEG_W     = 2;
  localparam int NUM_COEFS = 6;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 32;

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef coef_t [NUM_COEFS-1:0] coef_vec_t;

  // polynomial degree codes
  localparam logic [DEG_W-1:0] DEG_0 = 2'd0;
  localparam logic [DEG_W-1:0] DEG_1 = 2'd1;
  localparam logic [DEG_W-1:0] DEG_2 = 2'd2;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEGREE = 3'd0,
    REG_COEF_0 = 3'd1,
    REG_COEF_1 = 3'd2,
    REG_COEF_2 = 3'd3,
    REG_COEF_3 = 3'd4,
    REG_COEF_4 = 3'd5,
    REG_COEF_5 = 3'd6
  } cfg_reg_t;

  // control that travels alongside each pipeline stage
  typedef struct packed {
    logic vld;
    logic last;
  } ctl_t;

endpackage
`default_nettype wire

>>> hdl/psev_mono.sv
// stage one: monomials of the point, chosen per coefficient slot by degree
`default_nettype none
module psev_mono #(
  parameter int MAX_DEGREE = 2,
  parameter int COORD_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic [psev_pkg::COORD_W-1:0]  in_x,
  input  wire logic [psev_pkg::COORD_W-1:0]  in_y,
  input  wire psev_pkg::ctl_t                in_ctl,
  input  wire logic [psev_pkg::DEG_W-1:0]    degree,
  input  wire logic                          dn_rdy,
  output logic                               up_rdy,
  output psev_pkg::ctl_t                     out_ctl,
  output logic signed [2*COORD_BITS-1:0]     mono [psev_pkg::NUM_COEFS]
);
  import psev_pkg::*;

  localparam int MW = 2 * COORD_BITS;
  localparam logic [DEG_W-1:0] MAX_DEG = DEG_W'(MAX_DEGREE);

  logic signed [COORD_BITS-1:0] xs, ys;
  logic signed [MW-1:0]         xx, xy, yy;
  logic [DEG_W-1:0]             deg_eff;
  ctl_t                         ctl_r;
  logic signed [MW-1:0]         mono_r   [NUM_COEFS];
  logic signed [MW-1:0]         mono_nxt [NUM_COEFS];

  assign xs = signed'(in_x[COORD_BITS-1:0]);
  assign ys = signed'(in_y[COORD_BITS-1:0]);
  assign xx = MW'(xs) * MW'(xs);
  assign xy = MW'(xs) * MW'(ys);
  assign yy = MW'(ys) * MW'(ys);

  // codes above the build limit act as the limit
  assign deg_eff = (degree > MAX_DEG) ? MAX_DEG : degree;

  always_comb begin
    for (int k = 0; k < NUM_COEFS; k++) begin
      mono_nxt[k] = '0;
    end
    case (deg_eff)
      DEG_0: begin
        mono_nxt[0] = MW'(1);
      end
      DEG_1: begin
        mono_nxt[0] = MW'(1);
        mono_nxt[1] = MW'(xs);
        mono_nxt[2] = MW'(ys);
      end
      DEG_2: begin
        mono_nxt[0] = MW'(1);
        mono_nxt[1] = MW'(xs);
        mono_nxt[2] = xx;
        mono_nxt[3] = MW'(ys);
        mono_nxt[4] = xy;
        mono_nxt[5] = yy;
      end
      default: begin
        mono_nxt[0] = '0;
      end
    endcase
  end

  assign up_rdy = !ctl_r.vld || dn_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (up_rdy) begin
      ctl_r <= in_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (up_rdy) begin
      mono_r <= mono_nxt;
    end
  end

  assign out_ctl = ctl_r;
  assign mono    = mono_r;

endmodule
`default_nettype wire

>>> hdl/psev_terms.sv
// stage two: one coefficient times monomial product per slot
`default_nettype none
module psev_terms #(
  parameter int COORD_BITS = 16
) (
  input  wire logic                                       clk,
  input  wire logic                                       rst_n,
  input  wire psev_pkg::ctl_t                             in_ctl,
  input  wire logic signed [2*COORD_BITS-1:0]             mono [psev_pkg::NUM_COEFS],
  input  wire psev_pkg::coef_vec_t                        coef,
  input  wire logic                                       dn_rdy,
  output logic                                            up_rdy,
  output psev_pkg::ctl_t                                  out_ctl,
  output logic signed [psev_pkg::COEF_W+2*COORD_BITS-1:0] prod [psev_pkg::NUM_COEFS]
);
  import psev_pkg::*;

  localparam int PW = COEF_W + 2 * COORD_BITS;

  ctl_t                 ctl_r;
  logic signed [PW-1:0] prod_r   [NUM_COEFS];
  logic signed [PW-1:0] prod_nxt [NUM_COEFS];

  always_comb begin
    for (int k = 0; k < NUM_COEFS; k++) begin
      prod_nxt[k] = PW'($signed(coef[k])) * PW'(mono[k]);
    end
  end

  assign up_rdy = !ctl_r.vld || dn_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (up_rdy) begin
      ctl_r <= in_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (up_rdy) begin
      prod_r <= prod_nxt;
    end
  end

  assign out_ctl = ctl_r;
  assign prod    = prod_r;

endmodule
`default_nettype wire

>>> hdl/psev_sum.sv
// stages three to five: registered adder tree and 48-bit saturation
`default_nettype none
module psev_sum #(
  parameter int COORD_BITS = 16
) (
  input  wire logic                                       clk,
  input  wire logic                                       rst_n,
  input  wire psev_pkg::ctl_t                             in_ctl,
  input  wire logic signed [psev_pkg::COEF_W+2*COORD_BITS-1:0] prod [psev_pkg::NUM_COEFS],
  input  wire logic                                       dn_rdy,
  output logic                                            up_rdy,
  output psev_pkg::ctl_t                                  out_ctl,
  output logic signed [psev_pkg::Z_W-1:0]                 z,
  output logic                                            ovf
);
  import psev_pkg::*;

  localparam int PW = COEF_W + 2 * COORD_BITS;
  localparam int SW = PW + 3;
  localparam logic signed [SW-1:0] ZMAX = {{(SW-Z_W+1){1'b0}}, {(Z_W-1){1'b1}}};
  localparam logic signed [SW-1:0] ZMIN = ~ZMAX;

  ctl_t                 ctl3_r, ctl4_r, ctl5_r;
  logic                 rdy3, rdy4, rdy5;
  logic signed [SW-1:0] pair_r [3];
  logic signed [SW-1:0] tot_r;
  logic signed [SW-1:0] tot_nxt;
  logic signed [Z_W-1:0] z_r;
  logic                 ovf_r;

  assign rdy5   = !ctl5_r.vld || dn_rdy;
  assign rdy4   = !ctl4_r.vld || rdy5;
  assign rdy3   = !ctl3_r.vld || rdy4;
  assign up_rdy = rdy3;

  assign tot_nxt = pair_r[0] + pair_r[1] + pair_r[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl3_r <= '0;
      ctl4_r <= '0;
      ctl5_r <= '0;
    end else begin
      if (rdy3) begin
        ctl3_r <= in_ctl;
      end
      if (rdy4) begin
        ctl4_r <= ctl3_r;
      end
      if (rdy5) begin
        ctl5_r <= ctl4_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      for (int k = 0; k < 3; k++) begin
        pair_r[k] <= SW'(prod[2*k]) + SW'(prod[2*k+1]);
      end
    end
    if (rdy4) begin
      tot_r <= tot_nxt;
    end
    if (rdy5) begin
      if (tot_r > ZMAX) begin
        z_r   <= ZMAX[Z_W-1:0];
        ovf_r <= 1'b1;
      end else if (tot_r < ZMIN) begin
        z_r   <= ZMIN[Z_W-1:0];
        ovf_r <= 1'b1;
      end else begin
        z_r   <= tot_r[Z_W-1:0];
        ovf_r <= 1'b0;
      end
    end
  end

  assign out_ctl = ctl5_r;
  assign z       = z_r;
  assign ovf     = ovf_r;

endmodule
`default_nettype wire

>>> hdl/poly_surface_evaluator.sv
// top level of the polynomial surface evaluator
// an input transfer passes through the monomial, product, pairwise-sum, full-sum and saturation registers to the output
// throughput: one point per cycle, sustained while the output is not stalled
// each full stage holds while its successor cannot take its data, so bubbles close up under a stall
// reset (synchronous, rst_n low) empties the pipeline and clears degree and coefficients
`default_nettype none
module poly_surface_evaluator #(
  parameter int MAX_DEGREE = 2,
  parameter int COORD_BITS = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // input channel
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [psev_pkg::COORD_W-1:0]      in_x_coord,
  input  wire logic [psev_pkg::COORD_W-1:0]      in_y_coord,
  input  wire logic                              in_last_in,
  // result channel
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic signed [psev_pkg::Z_W-1:0]        out_z_value,
  output logic                                   out_overflow,
  output logic                                   out_last_out,
  // configuration write port
  input  wire logic                              cfg_we,
  input  wire logic [psev_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [psev_pkg::CFG_DAT_W-1:0]    cfg_wdata
);
  import psev_pkg::*;

  localparam int MW = 2 * COORD_BITS;
  localparam int PW = COEF_W + MW;

  // configuration registers
  logic [DEG_W-1:0] degree_r;
  coef_vec_t        coef_r;

  // inter-stage wiring
  ctl_t                 in_ctl, mono_ctl, term_ctl, sum_ctl;
  logic                 mono_rdy, term_rdy, sum_rdy;
  logic signed [MW-1:0] mono [NUM_COEFS];
  logic signed [PW-1:0] prod [NUM_COEFS];
  logic signed [Z_W-1:0] z;
  logic                 ovf;

  // register writes; an index beyond the list is dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      degree_r <= '0;
      coef_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DEGREE: degree_r  <= cfg_wdata[DEG_W-1:0];
        REG_COEF_0: coef_r[0] <= cfg_wdata;
        REG_COEF_1: coef_r[1] <= cfg_wdata;
        REG_COEF_2: coef_r[2] <= cfg_wdata;
        REG_COEF_3: coef_r[3] <= cfg_wdata;
        REG_COEF_4: coef_r[4] <= cfg_wdata;
        REG_COEF_5: coef_r[5] <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  assign in_ctl.vld  = in_valid;
  assign in_ctl.last = in_last_in;

  // stage one: 1, x, y, x and y squared and cross product, routed to coefficient slots by degree
  psev_mono #(
    .MAX_DEGREE (MAX_DEGREE),
    .COORD_BITS (COORD_BITS)
  ) u_mono (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_x    (in_x_coord),
    .in_y    (in_y_coord),
    .in_ctl  (in_ctl),
    .degree  (degree_r),
    .dn_rdy  (term_rdy),
    .up_rdy  (mono_rdy),
    .out_ctl (mono_ctl),
    .mono    (mono)
  );

  // stage two: six coefficient products in parallel, each exact
  psev_terms #(
    .COORD_BITS (COORD_BITS)
  ) u_terms (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ctl  (mono_ctl),
    .mono    (mono),
    .coef    (coef_r),
    .dn_rdy  (sum_rdy),
    .up_rdy  (term_rdy),
    .out_ctl (term_ctl),
    .prod    (prod)
  );

  // stages three to five: pairwise sums, full sum, then saturation to Q32.16
  psev_sum #(
    .COORD_BITS (COORD_BITS)
  ) u_sum (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ctl  (term_ctl),
    .prod    (prod),
    .dn_rdy  (!out_stall),
    .up_rdy  (sum_rdy),
    .out_ctl (sum_ctl),
    .z       (z),
    .ovf     (ovf)
  );

  // a transfer in is refused only when every stage is full and the output is stalled
  assign in_stall     = !mono_rdy;

  assign out_valid    = sum_ctl.vld;
  assign out_last_out = sum_ctl.last;
  assign out_z_value  = z;
  assign out_overflow = ovf;

endmodule
`default_nettype wire
